// File: rtl/phasor_box_multilook_defines.svh
// assertion macros for the phasor box multilook block
// used by the rtl files that check their own logic; no other dependencies
`ifndef PHASOR_BOX_MULTILOOK_DEFINES_SVH
`define PHASOR_BOX_MULTILOOK_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PBM_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PBM_ASSERT(lbl, prop, msg)
`define PBM_NEVER(lbl, cond, msg)
`endif
`endif

// File: rtl/pbm_pkg.sv
// types, constants and trig tables of the phasor box multilook block
// no dependencies
`default_nettype none
package pbm_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int TABLE_BITS    = 8;
  localparam int AMP_W         = 16;
  localparam int PH_W          = 16;
  localparam int ACC_W         = 44;
  localparam int CX_W          = 62;
  localparam int Z_W           = 28;
  localparam int MAG_W         = 16;
  localparam int PHO_W         = 15;
  localparam int LOOK_W        = 7;
  localparam int DIV_W         = 2 * LOOK_W;
  localparam int MAX_STAGES    = 24;

  localparam logic [25:0] INDEX_K      = 26'd42722830;
  localparam logic [29:0] INV_GAIN     = 30'd652032874;
  localparam logic signed [Z_W-1:0] PI_Q24 = 28'sd52707179;
  localparam logic signed [15:0] PHASE_LIMIT = 16'sd12868;

  typedef enum logic {REG_LOOK_LINES = 1'b0, REG_LOOK_SAMPLES = 1'b1} reg_idx_e;

  typedef logic signed [Z_W-1:0] atan_tbl_t [MAX_STAGES];
  localparam atan_tbl_t ATAN_Q24 = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
    28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768,
    28'sd16384, 28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
    28'sd256, 28'sd128, 28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2
  };

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } sums_t;

  typedef logic signed [15:0] rom_t [TABLE_ENTRIES];

  function automatic logic signed [15:0] to_q15(longint v);
    longint unsigned q;
    if (v < 0) v = 0;
    q = (longint'(v) + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return 16'(q);
  endfunction

  // restoring long division for table construction
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned quo, rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // quarter-wave taylor series in q30, folded into four quadrants
  function automatic rom_t build_rom(bit want_sine);
    rom_t            rom;
    longint unsigned x, x2, ts, tc;
    longint          ss, cc;
    int              q, r;
    logic signed [15:0] sq, cq;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      q  = (4 * i) >> TABLE_BITS;
      r  = 4 * i - q * TABLE_ENTRIES;
      x  = (64'd3373259426 * longint'(r)) >> (TABLE_BITS + 1);
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      cc = longint'(64'd1 << 30);
      for (int k = 1; k <= 12; k++) begin
        ts = udiv((ts * x2) >> 30, 64'((2 * k) * (2 * k + 1)));
        tc = udiv((tc * x2) >> 30, 64'((2 * k - 1) * (2 * k)));
        if (k[0]) begin
          ss = ss - longint'(ts);
          cc = cc - longint'(tc);
        end else begin
          ss = ss + longint'(ts);
          cc = cc + longint'(tc);
        end
      end
      sq = to_q15(ss);
      cq = to_q15(cc);
      unique case (q[1:0])
        2'd0:    rom[i] = want_sine ? sq : cq;
        2'd1:    rom[i] = want_sine ? cq : -sq;
        2'd2:    rom[i] = want_sine ? -sq : -cq;
        default: rom[i] = want_sine ? -cq : sq;
      endcase
    end
    return rom;
  endfunction

  localparam rom_t COS_ROM = build_rom(1'b0);
  localparam rom_t SIN_ROM = build_rom(1'b1);

endpackage
`default_nettype wire

// File: rtl/pbm_in_if.sv
// pixel input channel of the phasor box multilook block
// depends on pbm_pkg
`default_nettype none
interface pbm_in_if import pbm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [AMP_W-1:0]        amplitude;
  logic signed [PH_W-1:0]  phase_in;
  logic                    last_of_box;
  modport source (output valid, amplitude, phase_in, last_of_box, input ready);
  modport sink (input valid, amplitude, phase_in, last_of_box, output ready);
endinterface
`default_nettype wire

// File: rtl/pbm_out_if.sv
// result output channel of the phasor box multilook block
// depends on pbm_pkg
`default_nettype none
interface pbm_out_if import pbm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [MAG_W-1:0]        magnitude;
  logic signed [PHO_W-1:0] phase_out;
  modport source (output valid, magnitude, phase_out, input ready);
  modport sink (input valid, magnitude, phase_out, output ready);
endinterface
`default_nettype wire

// File: rtl/pbm_accum.sv
// table lookup, phasor products and box accumulators
// depends on pbm_pkg
`default_nettype none
module pbm_accum import pbm_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   take_i,
  input  wire logic [AMP_W-1:0]       amp_i,
  input  wire logic signed [PH_W-1:0] phase_i,
  input  wire logic                   last_i,
  output sums_t                       sums_o
);
  logic [PH_W-1:0]        ph_mag;
  logic [41:0]            idx_prod;
  logic                   v1_q, v2_q, v3_q;
  logic                   l1_q, l2_q, l3_q;
  logic                   neg1_q;
  logic [TABLE_BITS-1:0]  t1_q, idx;
  logic [AMP_W-1:0]       a1_q, a2_q;
  logic signed [15:0]     cos2_q, sin2_q;
  logic signed [32:0]     pre3_q, pim3_q;
  logic signed [ACC_W-1:0] re_q, im_q, re_d, im_d;

  assign ph_mag   = phase_i[PH_W-1] ? PH_W'(-phase_i) : PH_W'(phase_i);
  assign idx_prod = 42'(ph_mag) * 42'(INDEX_K);
  assign idx      = neg1_q ? TABLE_BITS'(-t1_q) : t1_q;
  assign re_d     = re_q + ACC_W'(pre3_q);
  assign im_d     = im_q + ACC_W'(pim3_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      re_q <= '0;
      im_q <= '0;
    end else begin
      v1_q <= take_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (v3_q) begin
        re_q <= l3_q ? '0 : re_d;
        im_q <= l3_q ? '0 : im_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q   <= idx_prod[40-TABLE_BITS +: TABLE_BITS];
    neg1_q <= phase_i[PH_W-1];
    a1_q   <= amp_i;
    l1_q   <= last_i;
    cos2_q <= COS_ROM[idx];
    sin2_q <= SIN_ROM[idx];
    a2_q   <= a1_q;
    l2_q   <= l1_q;
    pre3_q <= $signed({1'b0, a2_q}) * cos2_q;
    pim3_q <= $signed({1'b0, a2_q}) * sin2_q;
    l3_q   <= l2_q;
  end

  assign sums_o.start = v3_q && l3_q;
  assign sums_o.re    = re_d;
  assign sums_o.im    = im_d;
endmodule
`default_nettype wire

// File: rtl/pbm_cordic_cell.sv
// one vectoring rotation of the cordic chain
// depends on pbm_pkg
`default_nettype none
module pbm_cordic_cell import pbm_pkg::*; #(
  parameter int STAGE = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic valid_i,
  input  cordic_t   data_i,
  output logic      valid_o,
  output cordic_t   data_o
);
  cordic_t d_q;
  logic    v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_i.y > 0) begin
      d_q.x <= data_i.x + (data_i.y >>> STAGE);
      d_q.y <= data_i.y - (data_i.x >>> STAGE);
      d_q.z <= data_i.z + ATAN_Q24[STAGE];
    end else begin
      d_q.x <= data_i.x - (data_i.y >>> STAGE);
      d_q.y <= data_i.y + (data_i.x >>> STAGE);
      d_q.z <= data_i.z - ATAN_Q24[STAGE];
    end
  end

  assign valid_o = v_q;
  assign data_o  = d_q;
endmodule
`default_nettype wire

// File: rtl/pbm_finish.sv
// box finish: pi pre-rotation, cordic chain, gain, averaging divide, result register
// depends on pbm_pkg, pbm_cordic_cell and the assertion macro header
`default_nettype none
`include "phasor_box_multilook_defines.svh"
module pbm_finish import pbm_pkg::*; #(
  parameter int MAX_LOOK      = 64,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  sums_t                  sums_i,
  input  wire logic [LOOK_W-1:0] look_lines_i,
  input  wire logic [LOOK_W-1:0] look_samples_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic [MAG_W-1:0]       out_mag_o,
  output logic signed [PHO_W-1:0] out_ph_o,
  output logic                   done_o
);
  typedef enum logic [2:0] {F_IDLE, F_CORDIC, F_GAIN, F_SCALE, F_DIV, F_OUT} fin_state_e;

  fin_state_e            state_q;
  cordic_t               pre_q;
  logic                  pre_v_q, zero_q, out_v_q, done_q;
  cordic_t               link [CORDIC_STAGES+1];
  logic                  link_v [CORDIC_STAGES+1];
  logic signed [CX_W-1:0] ext_re, ext_im;
  logic [60:0]           ux;
  logic [58:0]           phi_q;
  logic [61:0]           plo_q;
  logic signed [Z_W-1:0] z_q;
  logic [59:0]           msum;
  logic [45:0]           m;
  logic [LOOK_W-1:0]     ll, ls;
  logic [DIV_W-1:0]      divisor;
  logic [29:0]           rem_q, dsh_q;
  logic [MAG_W-1:0]      quo_q, mag_q;
  logic [3:0]            cnt_q;
  logic signed [Z_W-1:0] zr;
  logic signed [15:0]    pr, pc;
  logic signed [PHO_W-1:0] ph_q;

  assign ext_re = CX_W'(sums_i.re) <<< 16;
  assign ext_im = CX_W'(sums_i.im) <<< 16;

  assign link[0]   = pre_q;
  assign link_v[0] = pre_v_q;
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    pbm_cordic_cell #(.STAGE(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_v[g]),
      .data_i  (link[g]),
      .valid_o (link_v[g+1]),
      .data_o  (link[g+1])
    );
  end

  assign ux = link[CORDIC_STAGES].x[CX_W-1] ? '0 : link[CORDIC_STAGES].x[60:0];

  always_comb begin
    ll = (look_lines_i == '0) ? LOOK_W'(1) : look_lines_i;
    ls = (look_samples_i == '0) ? LOOK_W'(1) : look_samples_i;
    if (32'(ll) > MAX_LOOK) ll = LOOK_W'(MAX_LOOK);
    if (32'(ls) > MAX_LOOK) ls = LOOK_W'(MAX_LOOK);
    divisor = DIV_W'(ll) * DIV_W'(ls);
  end

  assign msum = 60'(phi_q) + 60'(plo_q[61:32]);
  assign m    = msum[59:14];
  assign zr   = z_q + Z_W'(2048);
  assign pr   = 16'(zr >>> 12);
  assign pc   = (pr > PHASE_LIMIT) ? PHASE_LIMIT : ((pr < -PHASE_LIMIT) ? -PHASE_LIMIT : pr);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      pre_v_q <= 1'b0;
      out_v_q <= 1'b0;
      done_q  <= 1'b0;
      zero_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      pre_v_q <= (state_q == F_IDLE) && sums_i.start;
      done_q  <= (state_q == F_OUT) && (!out_v_q || out_ready_i);
      if (out_v_q && out_ready_i && state_q != F_OUT) out_v_q <= 1'b0;
      unique case (state_q)
        F_IDLE: begin
          if (sums_i.start) begin
            zero_q  <= (sums_i.re == '0) && (sums_i.im == '0);
            if (ext_re < 0) begin
              pre_q.x <= -ext_re;
              pre_q.y <= -ext_im;
              pre_q.z <= (sums_i.im >= 0) ? PI_Q24 : -PI_Q24;
            end else begin
              pre_q.x <= ext_re;
              pre_q.y <= ext_im;
              pre_q.z <= '0;
            end
            state_q <= F_CORDIC;
          end
        end
        F_CORDIC: begin
          if (link_v[CORDIC_STAGES]) begin
            phi_q   <= 59'(ux[60:32]) * 59'(INV_GAIN);
            plo_q   <= 62'(ux[31:0]) * 62'(INV_GAIN);
            z_q     <= link[CORDIC_STAGES].z;
            state_q <= F_GAIN;
          end
        end
        F_GAIN: begin
          dsh_q   <= 30'(divisor) << 15;
          cnt_q   <= 4'd15;
          ph_q    <= zero_q ? '0 : PHO_W'(pc);
          state_q <= F_SCALE;
        end
        F_SCALE: begin
          if (zero_q) begin
            mag_q   <= '0;
            state_q <= F_OUT;
          end else if (m >= 46'({divisor, 16'b0})) begin
            mag_q   <= '1;
            state_q <= F_OUT;
          end else begin
            rem_q   <= m[29:0];
            quo_q   <= '0;
            state_q <= F_DIV;
          end
        end
        F_DIV: begin
          if (rem_q >= dsh_q) begin
            rem_q <= rem_q - dsh_q;
            quo_q <= {quo_q[MAG_W-2:0], 1'b1};
          end else begin
            quo_q <= {quo_q[MAG_W-2:0], 1'b0};
          end
          dsh_q <= dsh_q >> 1;
          cnt_q <= cnt_q - 4'd1;
          if (cnt_q == '0) begin
            mag_q   <= (rem_q >= dsh_q) ? {quo_q[MAG_W-2:0], 1'b1} : {quo_q[MAG_W-2:0], 1'b0};
            state_q <= F_OUT;
          end
        end
        F_OUT: begin
          if (!out_v_q || out_ready_i) begin
            out_mag_o <= mag_q;
            out_ph_o  <= ph_q;
            out_v_q   <= 1'b1;
            state_q   <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign done_o      = done_q;

  `PBM_ASSERT(a_start_when_idle, sums_i.start |-> state_q == F_IDLE, "box finish started while busy")
  `PBM_ASSERT(a_chain_in_cordic, link_v[CORDIC_STAGES] |-> state_q == F_CORDIC, "cordic result outside its state")
  `PBM_NEVER(a_phase_bound, out_v_q && (out_ph_o > PHO_W'(12868)) && !out_ph_o[PHO_W-1], "phase above bound")
endmodule
`default_nettype wire

// File: rtl/phasor_box_multilook.sv
// a box's sums pass the cordic chain and then the bit-serial averaging divide, which is
// skipped when the magnitude is zero or saturates
// throughput: one pixel per cycle within a box; after the last pixel input stalls
// until the result is loaded into the output register and the registered done flag
// has cleared busy, so the stall covers the cordic chain and the bit-serial averaging divide
// reset clears accumulators, look registers to 5 and 1
// top level of the phasor box multilook block; depends on pbm_pkg, pbm_in_if,
// pbm_out_if, pbm_accum, pbm_finish and the assertion macro header
`default_nettype none
`include "phasor_box_multilook_defines.svh"
module phasor_box_multilook import pbm_pkg::*; #(
  parameter int MAX_LOOK      = 64,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [LOOK_W-1:0] cfg_data_i,
  pbm_in_if.sink                 in_i,
  pbm_out_if.source              out_o
);
  logic [LOOK_W-1:0] lines_q, samples_q;
  logic              busy_q, take, done;
  sums_t             sums;

  assign in_i.ready = !busy_q;
  assign take       = in_i.valid && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q   <= LOOK_W'(5);
      samples_q <= LOOK_W'(1);
      busy_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_LOOK_LINES:   lines_q   <= cfg_data_i;
          REG_LOOK_SAMPLES: samples_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (take && in_i.last_of_box) busy_q <= 1'b1;
      else if (done) busy_q <= 1'b0;
    end
  end

  pbm_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (take),
    .amp_i   (in_i.amplitude),
    .phase_i (in_i.phase_in),
    .last_i  (in_i.last_of_box),
    .sums_o  (sums)
  );

  pbm_finish #(.MAX_LOOK(MAX_LOOK), .CORDIC_STAGES(CORDIC_STAGES)) u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sums_i         (sums),
    .look_lines_i   (lines_q),
    .look_samples_i (samples_q),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .out_mag_o      (out_o.magnitude),
    .out_ph_o       (out_o.phase_out),
    .done_o         (done)
  );

  `PBM_ASSERT(a_last_stalls, (take && in_i.last_of_box) |=> !in_i.ready, "input open after last pixel")
  `PBM_NEVER(a_done_needs_busy, done && !busy_q, "result without a pending box")
endmodule
`default_nettype wire
